/* hdl/mrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, codes and helpers shared by the mismatch run characterizer modules.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int CNT_W      = 40;
  localparam int HIST_BINS  = 26;
  localparam int BIN_W      = 5;
  localparam int PAGE_OFF_W = 16;
  localparam int SHIFT_W    = 5;
  localparam int LIMIT_W    = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [BIN_W-1:0]   LAST_BIN         = BIN_W'(HIST_BINS - 1);
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MIN   = 5'd4;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;
  localparam logic [LIMIT_W-1:0] SHOW_LIMIT_RESET = 8'd12;

  typedef enum logic [0:0] {
    OP_COMPARE = 1'b0,
    OP_FINISH  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SHIFT = 1'b0,
    CFG_SHOW_LIMIT = 1'b1
  } cfg_index_e;

  typedef enum logic [3:0] {
    KIND_RUN       = 4'd0,
    KIND_TAIL      = 4'd1,
    KIND_COMPARED  = 4'd2,
    KIND_BAD       = 4'd3,
    KIND_RUNS      = 4'd4,
    KIND_ZERO_RUNS = 4'd5,
    KIND_ALIGNED   = 4'd6,
    KIND_PAGE_LEN  = 4'd7,
    KIND_BIN       = 4'd8
  } record_kind_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_TOT,
    ST_BIN
  } ctrl_state_e;

  typedef struct packed {
    logic [0:0] opcode;
    logic [7:0] ref_byte;
    logic [7:0] sus_byte;
  } in_req_t;

  typedef struct packed {
    logic [3:0]            record_kind;
    logic [CNT_W-1:0]      run_number;
    logic [CNT_W-1:0]      run_offset;
    logic [CNT_W-1:0]      run_length;
    logic [PAGE_OFF_W-1:0] page_offset;
    logic                  all_zero;
    logic [BIN_W-1:0]      bin_index;
    logic [CNT_W-1:0]      count_value;
    logic                  last_result;
  } out_rec_t;

  typedef struct packed {
    logic             compare;
    logic             finish;
    logic             emit_total;
    logic             emit_bin;
    record_kind_e     kind;
    logic [BIN_W-1:0] bin_idx;
    logic             last;
    logic             clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                 out_free;
    logic [HIST_BINS-1:0] hist_nz;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* hdl/mrc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_ctrl
// Sequencer: takes requests, then walks the totals and histogram bins of a
// finish sequence and orders the final clear.
// ----------------------------------------------------------------------------
module mrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mrc_pkg::in_req_t    in_req_i,
  output logic                in_stall_o,
  input  mrc_pkg::dp_status_t status_i,
  output mrc_pkg::ctrl_cmd_t  cmd_o
);
  import mrc_pkg::*;

  ctrl_state_e      state_q, state_d;
  record_kind_e     kind_q, kind_d;
  logic [BIN_W-1:0] idx_q, idx_d;
  logic             in_acc;
  logic             nz_above;
  logic             any_nz;

  assign any_nz   = |status_i.hist_nz;
  assign nz_above = |((status_i.hist_nz >> idx_q) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      kind_q  <= KIND_COMPARED;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    idx_d         = idx_q;
    in_stall_o    = 1'b1;
    in_acc        = 1'b0;
    cmd_o         = '0;
    cmd_o.kind    = kind_q;
    cmd_o.bin_idx = idx_q;
    case (state_q)
      ST_RUN: begin
        in_stall_o = !status_i.out_free;
        in_acc     = in_valid_i && status_i.out_free;
        if (in_acc) begin
          if (in_req_i.opcode == OP_FINISH) begin
            cmd_o.finish = 1'b1;
            kind_d       = KIND_COMPARED;
            state_d      = ST_TOT;
          end else begin
            cmd_o.compare = 1'b1;
          end
        end
      end
      ST_TOT: begin
        if (status_i.out_free) begin
          cmd_o.emit_total = 1'b1;
          if (kind_q == KIND_PAGE_LEN) begin
            idx_d = '0;
            if (any_nz) begin
              state_d = ST_BIN;
            end else begin
              cmd_o.last  = 1'b1;
              cmd_o.clear = 1'b1;
              state_d     = ST_RUN;
            end
          end else begin
            kind_d = record_kind_e'(kind_q + 4'd1);
          end
        end
      end
      ST_BIN: begin
        if (status_i.hist_nz[idx_q]) begin
          if (status_i.out_free) begin
            cmd_o.emit_bin = 1'b1;
            if (!nz_above) begin
              cmd_o.last  = 1'b1;
              cmd_o.clear = 1'b1;
              state_d     = ST_RUN;
            end else begin
              idx_d = idx_q + BIN_W'(1);
            end
          end
        end else if (idx_q == LAST_BIN) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_RUN;
        end else begin
          idx_d = idx_q + BIN_W'(1);
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

endmodule

/* hdl/mrc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_dp
// Datapath: run tracking, saturating counters, length histogram, config
// registers and the output record register.
// ----------------------------------------------------------------------------
module mrc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mrc_pkg::ctrl_cmd_t                  cmd_i,
  input  mrc_pkg::in_req_t                    in_req_i,
  input  logic                                cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mrc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                out_stall_i,
  output mrc_pkg::dp_status_t                 status_o,
  output logic                                out_valid_o,
  output mrc_pkg::out_rec_t                   out_rec_o
);
  import mrc_pkg::*;

  logic [SHIFT_W-1:0]   page_shift_q, page_shift_d;
  logic [LIMIT_W-1:0]   show_limit_q, show_limit_d;
  logic                 open_q, open_d;
  logic [CNT_W-1:0]     start_q, start_d;
  logic                 zero_q, zero_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     bad_q, bad_d;
  logic [CNT_W-1:0]     runs_q, runs_d;
  logic [CNT_W-1:0]     zruns_q, zruns_d;
  logic [CNT_W-1:0]     aligned_q, aligned_d;
  logic [CNT_W-1:0]     pglen_q, pglen_d;
  logic [LIMIT_W-1:0]   shown_q, shown_d;
  logic [CNT_W-1:0]     len_q, len_d;
  logic [BIN_W-1:0]     bin_q, bin_d;
  logic [CNT_W-1:0]     thr_q, thr_d;
  logic [CNT_W-1:0]     hist_q [HIST_BINS];
  logic [CNT_W-1:0]     hist_d [HIST_BINS];
  logic [HIST_BINS-1:0] nz_q, nz_d;
  logic                 out_valid_q, out_valid_d;
  out_rec_t             out_rec_q, out_rec_d;

  logic [SHIFT_W-1:0]   eff_shift;
  logic [CNT_W-1:0]     pmask;
  logic [CNT_W-1:0]     psize;
  logic                 mism;
  logic                 step;
  logic                 out_free;

  always_comb begin
    if (page_shift_q < PAGE_SHIFT_MIN) begin
      eff_shift = PAGE_SHIFT_MIN;
    end else if (page_shift_q > PAGE_SHIFT_MAX) begin
      eff_shift = PAGE_SHIFT_MAX;
    end else begin
      eff_shift = page_shift_q;
    end
  end

  assign pmask    = ~({CNT_W{1'b1}} << eff_shift);
  assign psize    = CNT_W'(1) << eff_shift;
  assign mism     = in_req_i.ref_byte != in_req_i.sus_byte;
  assign step     = !(&pos_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.out_free = out_free;
  assign status_o.hist_nz  = nz_q;
  assign out_valid_o       = out_valid_q;
  assign out_rec_o         = out_rec_q;

  always_comb begin
    page_shift_d = page_shift_q;
    show_limit_d = show_limit_q;
    open_d       = open_q;
    start_d      = start_q;
    zero_d       = zero_q;
    pos_d        = pos_q;
    bad_d        = bad_q;
    runs_d       = runs_q;
    zruns_d      = zruns_q;
    aligned_d    = aligned_q;
    pglen_d      = pglen_q;
    shown_d      = shown_q;
    len_d        = len_q;
    bin_d        = bin_q;
    thr_d        = thr_q;
    hist_d       = hist_q;
    nz_d         = nz_q;
    out_rec_d    = out_rec_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_idx_i))
        CFG_PAGE_SHIFT: page_shift_d = cfg_data_i[SHIFT_W-1:0];
        CFG_SHOW_LIMIT: show_limit_d = cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.compare) begin
      pos_d = sat_inc(pos_q);
      if (mism) begin
        bad_d = sat_inc(bad_q);
        if (!open_q) begin
          open_d  = 1'b1;
          start_d = pos_q;
          zero_d  = in_req_i.sus_byte == 8'd0;
          len_d   = step ? CNT_W'(1) : '0;
          bin_d   = '0;
          thr_d   = CNT_W'(1);
        end else begin
          zero_d = zero_q && (in_req_i.sus_byte == 8'd0);
          if (step) begin
            len_d = len_q + CNT_W'(1);
            // thr holds 2^(bin+1)-1, so the bin moves up when the length
            // reaches the next power of two
            if (len_q == thr_q && bin_q != LAST_BIN) begin
              bin_d = bin_q + BIN_W'(1);
              thr_d = {thr_q[CNT_W-2:0], 1'b1};
            end
          end
        end
      end else if (open_q) begin
        open_d       = 1'b0;
        runs_d       = sat_inc(runs_q);
        hist_d[bin_q] = sat_inc(hist_q[bin_q]);
        nz_d[bin_q]  = 1'b1;
        if (zero_q) begin
          zruns_d = sat_inc(zruns_q);
        end
        if ((start_q & pmask) == '0) begin
          aligned_d = sat_inc(aligned_q);
        end
        if (len_q == psize) begin
          pglen_d = sat_inc(pglen_q);
        end
        if (shown_q < show_limit_q) begin
          shown_d                 = shown_q + LIMIT_W'(1);
          out_valid_d             = 1'b1;
          out_rec_d               = '0;
          out_rec_d.record_kind   = KIND_RUN;
          out_rec_d.run_number    = sat_inc(runs_q);
          out_rec_d.run_offset    = start_q;
          out_rec_d.run_length    = len_q;
          out_rec_d.page_offset   = start_q[PAGE_OFF_W-1:0] & pmask[PAGE_OFF_W-1:0];
          out_rec_d.all_zero      = zero_q;
          out_rec_d.bin_index     = bin_q;
        end
      end
    end

    if (cmd_i.finish && open_q) begin
      // tail run counts toward runs and zero runs only
      runs_d = sat_inc(runs_q);
      if (zero_q) begin
        zruns_d = sat_inc(zruns_q);
      end
      out_valid_d             = 1'b1;
      out_rec_d               = '0;
      out_rec_d.record_kind   = KIND_TAIL;
      out_rec_d.run_number    = sat_inc(runs_q);
      out_rec_d.run_offset    = start_q;
      out_rec_d.run_length    = len_q;
      out_rec_d.page_offset   = start_q[PAGE_OFF_W-1:0] & pmask[PAGE_OFF_W-1:0];
      out_rec_d.all_zero      = zero_q;
      out_rec_d.bin_index     = bin_q;
    end

    if (cmd_i.emit_total) begin
      out_valid_d             = 1'b1;
      out_rec_d               = '0;
      out_rec_d.record_kind   = cmd_i.kind;
      out_rec_d.last_result   = cmd_i.last;
      case (cmd_i.kind)
        KIND_COMPARED:  out_rec_d.count_value = pos_q;
        KIND_BAD:       out_rec_d.count_value = bad_q;
        KIND_RUNS:      out_rec_d.count_value = runs_q;
        KIND_ZERO_RUNS: out_rec_d.count_value = zruns_q;
        KIND_ALIGNED:   out_rec_d.count_value = aligned_q;
        KIND_PAGE_LEN:  out_rec_d.count_value = pglen_q;
        default:        out_rec_d.count_value = '0;
      endcase
    end

    if (cmd_i.emit_bin) begin
      out_valid_d             = 1'b1;
      out_rec_d               = '0;
      out_rec_d.record_kind   = KIND_BIN;
      out_rec_d.bin_index     = cmd_i.bin_idx;
      out_rec_d.count_value   = hist_q[cmd_i.bin_idx];
      out_rec_d.last_result   = cmd_i.last;
    end

    if (cmd_i.clear) begin
      open_d    = 1'b0;
      start_d   = '0;
      zero_d    = 1'b1;
      pos_d     = '0;
      bad_d     = '0;
      runs_d    = '0;
      zruns_d   = '0;
      aligned_d = '0;
      pglen_d   = '0;
      shown_d   = '0;
      len_d     = '0;
      bin_d     = '0;
      thr_d     = CNT_W'(1);
      nz_d      = '0;
      for (int i = 0; i < HIST_BINS; i++) begin
        hist_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= PAGE_SHIFT_RESET;
      show_limit_q <= SHOW_LIMIT_RESET;
      open_q       <= 1'b0;
      start_q      <= '0;
      zero_q       <= 1'b1;
      pos_q        <= '0;
      bad_q        <= '0;
      runs_q       <= '0;
      zruns_q      <= '0;
      aligned_q    <= '0;
      pglen_q      <= '0;
      shown_q      <= '0;
      len_q        <= '0;
      bin_q        <= '0;
      thr_q        <= CNT_W'(1);
      nz_q         <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < HIST_BINS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      page_shift_q <= page_shift_d;
      show_limit_q <= show_limit_d;
      open_q       <= open_d;
      start_q      <= start_d;
      zero_q       <= zero_d;
      pos_q        <= pos_d;
      bad_q        <= bad_d;
      runs_q       <= runs_d;
      zruns_q      <= zruns_d;
      aligned_q    <= aligned_d;
      pglen_q      <= pglen_d;
      shown_q      <= shown_d;
      len_q        <= len_d;
      bin_q        <= bin_d;
      thr_q        <= thr_d;
      nz_q         <= nz_d;
      out_valid_q  <= out_valid_d;
      hist_q       <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q <= out_rec_d;
  end

endmodule

/* hdl/mismatch_run_characterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mismatch_run_characterizer
// Tracks runs of differing bytes between two streams and reports them.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_req_i): a compare request
// carries one reference and one suspect byte; a finish request closes the
// session. Compare requests are taken one per cycle while in_stall_o is low.
// A run closed by an equal pair yields one run record in the next cycle
// while fewer than show_limit runs have been shown.
// A finish request yields an optional tail record, six totals and the nonzero
// histogram bins, the final record flagged by last_result. The totals go out
// in turn; the bins are scanned one per cycle, unless the output stalls, up
// to the highest nonzero one, and the input is held off until the final
// record. All counters and the histogram are cleared with the final record.
// Output channel (out_valid_o / out_stall_i / out_rec_o): one record
// register; while it holds a stalled record, every request is held
// off. Configuration (page_shift, show_limit) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i and survives a finish.
// Reset: asynchronous, active low; config returns to its defaults and all
// counters, the histogram and the output register are emptied.
// ----------------------------------------------------------------------------
module mismatch_run_characterizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mrc_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrc_pkg::out_rec_t             out_rec_o,
  input  logic                          cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mrc_pkg::CFG_W-1:0]     cfg_data_i
);
  import mrc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_rec_o   (out_rec_o)
  );

endmodule

/* hdl/mrc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks on the mismatch run characterizer, bound to the top.
// ----------------------------------------------------------------------------
module mrc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input mrc_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mrc_pkg::out_rec_t out_rec_o
);
  import mrc_pkg::*;

  // a held record stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rec_o))
    else $error("stalled output record changed");

  // the drain after a finish holds off new requests
  a_finish_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.opcode == OP_FINISH) |=> in_stall_o)
    else $error("request taken right after finish");

  // only a page-length total or a bin record closes a finish sequence
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rec_o.last_result |->
      (out_rec_o.record_kind == KIND_PAGE_LEN) || (out_rec_o.record_kind == KIND_BIN))
    else $error("last flag on wrong record kind");

  // run ordinals count from one
  a_run_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_rec_o.record_kind == KIND_RUN) ||
                    (out_rec_o.record_kind == KIND_TAIL)) |->
      (out_rec_o.run_number != '0) && (out_rec_o.count_value == '0))
    else $error("bad run record");

endmodule

bind mismatch_run_characterizer mrc_checker u_mrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rec_o   (out_rec_o)
);

/* sim/mismatch_run_characterizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mismatch_run_characterizer_tb
// Self-checking bench: drives byte-pair compare and finish requests through
// several configuration and idling phases. An in-bench run tracker predicts
// every run, tail, total and histogram record, and the monitor checks each
// record field by field in order.
// ----------------------------------------------------------------------------
module mismatch_run_characterizer_tb;
  import mrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 14;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rec_t out_rec;
  logic     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  mismatch_run_characterizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rec_o  (out_rec),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_req_t  req_queue[$];
  out_rec_t expected_recs[$];
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       errors = 0;
  int       quiet_cycles = 0;
  int       gen_pos = 0;
  int       queued_items = 0;

  // run tracker state, mirrors the block
  logic [SHIFT_W-1:0] page_shift_cfg = PAGE_SHIFT_RESET;
  logic [LIMIT_W-1:0] show_limit_cfg = SHOW_LIMIT_RESET;
  logic               open_run;
  logic [CNT_W-1:0]   start_off;
  logic               zero_seen;
  logic [CNT_W-1:0]   byte_pos;
  logic [CNT_W-1:0]   bad_total;
  logic [CNT_W-1:0]   run_total;
  logic [CNT_W-1:0]   zero_run_total;
  logic [CNT_W-1:0]   aligned_total;
  logic [CNT_W-1:0]   page_len_total;
  logic [LIMIT_W-1:0] shown_total;
  logic [CNT_W-1:0]   len_hist[HIST_BINS];

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic int clamp_shift(logic [SHIFT_W-1:0] s);
    if (s < PAGE_SHIFT_MIN) return PAGE_SHIFT_MIN;
    if (s > PAGE_SHIFT_MAX) return PAGE_SHIFT_MAX;
    return s;
  endfunction

  function automatic logic [BIN_W-1:0] length_bin(logic [CNT_W-1:0] len);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int k = 1; k < HIST_BINS; k++)
      if (len >= (CNT_W'(1) << k)) b = BIN_W'(k);
    return b;
  endfunction

  function automatic out_rec_t make_rec(record_kind_e kind, logic [CNT_W-1:0] num,
                                        logic [CNT_W-1:0] off, logic [CNT_W-1:0] len,
                                        logic [PAGE_OFF_W-1:0] pgoff, logic zero,
                                        logic [BIN_W-1:0] bin, logic [CNT_W-1:0] cnt);
    out_rec_t r;
    r.record_kind = kind;
    r.run_number  = num;
    r.run_offset  = off;
    r.run_length  = len;
    r.page_offset = pgoff;
    r.all_zero    = zero;
    r.bin_index   = bin;
    r.count_value = cnt;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic void clear_tracker();
    open_run       = 1'b0;
    start_off      = '0;
    zero_seen      = 1'b1;
    byte_pos       = '0;
    bad_total      = '0;
    run_total      = '0;
    zero_run_total = '0;
    aligned_total  = '0;
    page_len_total = '0;
    shown_total    = '0;
    for (int i = 0; i < HIST_BINS; i++) len_hist[i] = '0;
  endfunction

  initial clear_tracker();

  // works out the records caused by one accepted request
  function automatic void predict_records(in_req_t r);
    logic [CNT_W-1:0] pmask;
    logic [CNT_W-1:0] len;
    logic [BIN_W-1:0] bin;
    out_rec_t         recs[$];
    out_rec_t         tmp;
    pmask = (CNT_W'(1) << clamp_shift(page_shift_cfg)) - 1'b1;
    if (opcode_e'(r.opcode) == OP_COMPARE) begin
      if (r.ref_byte != r.sus_byte) begin
        bad_total = bump(bad_total);
        if (!open_run) begin
          open_run  = 1'b1;
          start_off = byte_pos;
          zero_seen = 1'b1;
        end
        if (r.sus_byte != 8'd0) zero_seen = 1'b0;
      end else if (open_run) begin
        len = byte_pos - start_off;
        bin = length_bin(len);
        run_total = bump(run_total);
        len_hist[bin] = bump(len_hist[bin]);
        if (zero_seen) zero_run_total = bump(zero_run_total);
        if ((start_off & pmask) == '0) aligned_total = bump(aligned_total);
        if (len == pmask + 1'b1) page_len_total = bump(page_len_total);
        if (shown_total < show_limit_cfg) begin
          expected_recs.push_back(make_rec(KIND_RUN, run_total, start_off, len,
                                           PAGE_OFF_W'(start_off & pmask), zero_seen,
                                           bin, '0));
          shown_total++;
        end
        open_run = 1'b0;
      end
      byte_pos = bump(byte_pos);
      return;
    end
    // finish: tail run first, it stays out of the histogram and page counters
    if (open_run) begin
      len = byte_pos - start_off;
      run_total = bump(run_total);
      if (zero_seen) zero_run_total = bump(zero_run_total);
      recs.push_back(make_rec(KIND_TAIL, run_total, start_off, len,
                              PAGE_OFF_W'(start_off & pmask), zero_seen,
                              length_bin(len), '0));
    end
    recs.push_back(make_rec(KIND_COMPARED,  '0, '0, '0, '0, 1'b0, '0, byte_pos));
    recs.push_back(make_rec(KIND_BAD,       '0, '0, '0, '0, 1'b0, '0, bad_total));
    recs.push_back(make_rec(KIND_RUNS,      '0, '0, '0, '0, 1'b0, '0, run_total));
    recs.push_back(make_rec(KIND_ZERO_RUNS, '0, '0, '0, '0, 1'b0, '0, zero_run_total));
    recs.push_back(make_rec(KIND_ALIGNED,   '0, '0, '0, '0, 1'b0, '0, aligned_total));
    recs.push_back(make_rec(KIND_PAGE_LEN,  '0, '0, '0, '0, 1'b0, '0, page_len_total));
    for (int i = 0; i < HIST_BINS; i++)
      if (len_hist[i] != '0)
        recs.push_back(make_rec(KIND_BIN, '0, '0, '0, '0, 1'b0, BIN_W'(i), len_hist[i]));
    tmp = recs.pop_back();
    tmp.last_result = 1'b1;
    recs.push_back(tmp);
    foreach (recs[i]) expected_recs.push_back(recs[i]);
    clear_tracker();
  endfunction

  // driver: holds a request until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_records(in_req);
      if (!in_valid || !in_stall) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= req_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // monitor: checks records in order, stalls at random
  always @(posedge clk_i) begin
    out_rec_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_recs.size() == 0) begin
          $display("%0t: unexpected record expected none actual %h", $time, out_rec);
          errors++;
        end else begin
          want = expected_recs.pop_front();
          check_field("record_kind", want.record_kind, out_rec.record_kind);
          check_field("run_number",  want.run_number,  out_rec.run_number);
          check_field("run_offset",  want.run_offset,  out_rec.run_offset);
          check_field("run_length",  want.run_length,  out_rec.run_length);
          check_field("page_offset", want.page_offset, out_rec.page_offset);
          check_field("all_zero",    want.all_zero,    out_rec.all_zero);
          check_field("bin_index",   want.bin_index,   out_rec.bin_index);
          check_field("count_value", want.count_value, out_rec.count_value);
          check_field("last_result", want.last_result, out_rec.last_result);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d records still expected", $time, expected_recs.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic push_compare(logic [7:0] a, logic [7:0] b);
    in_req_t r;
    r.opcode   = OP_COMPARE;
    r.ref_byte = a;
    r.sus_byte = b;
    req_queue.push_back(r);
    gen_pos++;
    queued_items++;
  endtask

  task automatic push_finish();
    in_req_t r;
    r.opcode   = OP_FINISH;
    r.ref_byte = 8'($urandom);
    r.sus_byte = 8'($urandom);
    req_queue.push_back(r);
    gen_pos = 0;
    queued_items++;
  endtask

  task automatic push_equal();
    logic [7:0] v;
    v = 8'($urandom);
    push_compare(v, v);
  endtask

  task automatic push_diff(bit zero_sus);
    logic [7:0] s;
    s = zero_sus ? 8'd0 : 8'($urandom_range(1, 255));
    push_compare(s ^ 8'($urandom_range(1, 255)), s);
  endtask

  // a session of runs with random content, ended by a finish
  task automatic add_session();
    int  n_runs;
    int  len;
    int  pg;
    bit  zero_sus;
    pg = 1 << clamp_shift(page_shift_cfg);
    n_runs = $urandom_range(1, 2);
    for (int i = 0; i < n_runs; i++) begin
      if ($urandom_range(3) == 0 && pg <= 64)
        while (gen_pos % pg != 0) push_equal();
      repeat ($urandom_range(0, 3)) push_equal();
      case ($urandom_range(9))
        0: len = 1 << $urandom_range(0, 4);
        1: len = (1 << $urandom_range(1, 4)) - 1;
        2: len = (pg <= 16) ? pg : 1;
        default: len = $urandom_range(1, 6);
      endcase
      zero_sus = ($urandom_range(2) == 0);
      repeat (len) begin
        // occasional noise may break the run or spoil its zero flag
        if ($urandom_range(19) == 0) push_compare(8'($urandom), 8'($urandom));
        else push_diff(zero_sus);
      end
    end
    if ($urandom_range(1) == 1) push_equal();
    push_finish();
  endtask

  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || expected_recs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_W-1:0] shift, logic [CFG_W-1:0] limit);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PAGE_SHIFT;
    cfg_data <= shift;
    page_shift_cfg = shift[SHIFT_W-1:0];
    @(posedge clk_i);
    cfg_idx  <= CFG_SHOW_LIMIT;
    cfg_data <= limit;
    show_limit_cfg = limit;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int start;
    int shift_tab[5] = '{4, 16, 0, 8, 31};
    int limit_tab[5] = '{255, 0, 1, 7, 255};
    int idle_tab[5]  = '{0, 79, 0, 25, 0};
    int stall_tab[5] = '{0, 0, 79, 25, 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at reset config
    push_finish();                      // empty session
    push_compare(8'h01, 8'h00);         // zero run at offset zero, aligned
    push_compare(8'h80, 8'h80);
    push_compare(8'h00, 8'hFF);         // nonzero run of two
    push_compare(8'hFF, 8'h00);
    push_compare(8'h7F, 8'h7F);
    push_compare(8'h55, 8'h00);         // zero run of three
    push_compare(8'hAA, 8'h00);
    push_compare(8'hFF, 8'h00);
    push_compare(8'h00, 8'h00);
    push_compare(8'h00, 8'h01);         // left open for the tail record
    push_finish();
    push_compare(8'h00, 8'h00);
    push_compare(8'hFF, 8'hFE);         // tail run of two, not all zero
    push_compare(8'hFF, 8'h00);
    push_finish();
    push_finish();
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      set_config(CFG_W'(shift_tab[p]), CFG_W'(limit_tab[p]));
      @(negedge clk_i);
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      start = queued_items;
      while (queued_items - start < PHASE_ITEMS) add_session();
      wait_drained();
    end

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
